// ===== design/nmea_gga_position_parser_assert.svh =====
// ----------------------------------------------------------------------------
// NMEA GGA position parser: assertion macros
// Shorthand for clocked assertions, disabled while reset is held.
// ----------------------------------------------------------------------------
`ifndef NMEA_GGA_POSITION_PARSER_ASSERT_SVH
`define NMEA_GGA_POSITION_PARSER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define NGP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define NGP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ngp_pkg.sv =====
// ----------------------------------------------------------------------------
// NMEA GGA position parser package
// Types, character codes, limits and tables shared by the parser files.
// ----------------------------------------------------------------------------
package ngp_pkg;

  typedef enum logic [1:0] {
    ST_VALID      = 2'd0,
    ST_NOFIX      = 2'd1,
    ST_INCOMPLETE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    FLD_TIME = 3'd0,
    FLD_LAT  = 3'd1,
    FLD_NS   = 3'd2,
    FLD_LON  = 3'd3,
    FLD_EW   = 3'd4,
    FLD_REST = 3'd5
  } field_t;

  typedef enum logic [1:0] {
    JOB_LAT  = 2'd0,
    JOB_LON  = 2'd1,
    JOB_EMIT = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    status_t   status;
    logic      lat_neg;
    logic      lon_neg;
  } job_t;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_W     = 8'h57;

  localparam int          FRAC_DIGITS = 5;
  localparam logic [2:0]  FRAC_LIM    = (FRAC_DIGITS > 7) ? 3'd7 :
                                        ((FRAC_DIGITS < 1) ? 3'd1 : 3'(FRAC_DIGITS));
  localparam logic [22:0] MIN_ACC_MAX = 23'h7FFFFF;
  localparam logic [7:0]  DEG_ACC_MAX = 8'd255;
  localparam logic [3:0]  DIG_MAX     = 4'd15;
  localparam logic [2:0]  HDR_LEN     = 3'd6;
  localparam logic [2:0]  SKIP_LEN    = 3'd7;

  localparam logic [30:0] LAT_LIMIT   = 31'd900000000;
  localparam logic [30:0] LON_LIMIT   = 31'd1800000000;
  localparam logic [23:0] DEG_SCALE   = 24'd10000000;
  // ceil(2^30 / 60): exact quotient for any dividend below 2^24
  localparam logic [24:0] DIV60_RECIP = 25'd17895698;
  // 60 * (LON_LIMIT + 1): any dividend at or above this saturates
  localparam logic [47:0] MIN_SAT     = 48'd108000000060;

  function automatic logic [7:0] hdr_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h24; // $
      3'd1:    c = 8'h47; // G
      3'd2:    c = 8'h50; // P
      3'd3:    c = 8'h47; // G
      3'd4:    c = 8'h47; // G
      3'd5:    c = 8'h41; // A
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // 10^(7 - seen)
  function automatic logic [23:0] frac_scale(input logic [2:0] seen);
    logic [23:0] p;
    case (seen)
      3'd0:    p = 24'd10000000;
      3'd1:    p = 24'd1000000;
      3'd2:    p = 24'd100000;
      3'd3:    p = 24'd10000;
      3'd4:    p = 24'd1000;
      3'd5:    p = 24'd100;
      3'd6:    p = 24'd10;
      default: p = 24'd1;
    endcase
    return p;
  endfunction

endpackage

// ===== design/nmea_gga_position_parser.sv =====
// The result of a line passes through pipeline stages 1 to 6 and the output register to out_valid.
// The parser takes one byte per cycle while in_stall is low and updates its state per accepted byte.
// Coordinate scaling runs in a 6-stage pipeline with bubble collapse; in_stall rises
// only when all stages are occupied behind a result held by out_stall.
// Reset (rst_n low, synchronous) clears the parser to start of line and empties the
// pipeline and the output register.
// ----------------------------------------------------------------------------
// NMEA GGA position parser
// Parses $GPGGA lines byte by byte and emits latitude/longitude in 1e-7 degree.
// ----------------------------------------------------------------------------
module nmea_gga_position_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [30:0] out_latitude_e7,
  output logic signed [31:0] out_longitude_e7
);

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  logic [2:0]       cp_r, cp_nxt;
  logic             hok_r, hok_nxt;
  ngp_pkg::field_t  fi_r, fi_nxt;
  logic [3:0]       dig_r, dig_nxt;
  logic             stop_r, stop_nxt;
  logic             frac_r, frac_nxt;
  logic [7:0]       deg_r, deg_nxt;
  logic [22:0]      min_r, min_nxt;
  logic [2:0]       seen_r, seen_nxt;
  logic             latneg_r, latneg_nxt;
  logic             lonneg_r, lonneg_nxt;
  ngp_pkg::status_t pr_r, pr_nxt;

  logic                 in_acc;
  logic                 issue;
  ngp_pkg::job_kind_t   issue_kind;
  logic                 clear_req;
  logic                 line_end;
  logic                 is_digit;
  logic [3:0]           dval;
  logic [3:0]           deg_len;
  logic                 stop_eff;
  logic [11:0]          deg_mul;
  logic [26:0]          min_mul;

  assign is_digit = (in_rx_byte >= ngp_pkg::CH_ZERO) && (in_rx_byte <= ngp_pkg::CH_NINE);
  assign dval     = 4'(in_rx_byte - ngp_pkg::CH_ZERO);
  assign deg_len  = (fi_r == ngp_pkg::FLD_LAT) ? 4'd2 : 4'd3;
  assign stop_eff = (dig_r == deg_len) ? 1'b0 : stop_r;
  assign deg_mul  = 12'(deg_r) * 12'd10 + 12'(dval);
  assign min_mul  = 27'(min_r) * 27'd10 + 27'(dval);

  always_comb begin
    cp_nxt     = cp_r;
    hok_nxt    = hok_r;
    fi_nxt     = fi_r;
    dig_nxt    = dig_r;
    stop_nxt   = stop_r;
    frac_nxt   = frac_r;
    deg_nxt    = deg_r;
    min_nxt    = min_r;
    seen_nxt   = seen_r;
    latneg_nxt = latneg_r;
    lonneg_nxt = lonneg_r;
    pr_nxt     = pr_r;
    issue      = 1'b0;
    issue_kind = ngp_pkg::JOB_EMIT;
    clear_req  = 1'b0;
    line_end   = 1'b0;

    if (in_rx_byte == ngp_pkg::CH_LF) begin
      // drop line feeds
    end else if (in_rx_byte == ngp_pkg::CH_CR) begin
      line_end = 1'b1;
      if (hok_r && (cp_r >= ngp_pkg::HDR_LEN)) begin
        issue      = 1'b1;
        issue_kind = ngp_pkg::JOB_EMIT;
      end
    end else if (cp_r < ngp_pkg::SKIP_LEN) begin
      if ((cp_r < ngp_pkg::HDR_LEN) && (in_rx_byte != ngp_pkg::hdr_char(cp_r))) begin
        hok_nxt = 1'b0;
      end
      cp_nxt = cp_r + 3'd1;
    end else if (hok_r) begin
      case (fi_r)
        ngp_pkg::FLD_TIME: begin
          if (in_rx_byte == ngp_pkg::CH_COMMA) begin
            fi_nxt    = ngp_pkg::FLD_LAT;
            clear_req = 1'b1;
          end
        end
        ngp_pkg::FLD_LAT, ngp_pkg::FLD_LON: begin
          if (in_rx_byte == ngp_pkg::CH_COMMA) begin
            clear_req = 1'b1;
            if ((fi_r == ngp_pkg::FLD_LAT) && (dig_r == 4'd0)) begin
              pr_nxt = ngp_pkg::ST_NOFIX;
              fi_nxt = ngp_pkg::FLD_REST;
            end else begin
              issue = 1'b1;
              if (fi_r == ngp_pkg::FLD_LAT) begin
                issue_kind = ngp_pkg::JOB_LAT;
              end else begin
                issue_kind = ngp_pkg::JOB_LON;
                pr_nxt     = ngp_pkg::ST_VALID;
              end
              fi_nxt = ngp_pkg::field_t'(fi_r + 3'd1);
            end
          end else begin
            if (dig_r < deg_len) begin
              if (!stop_r && is_digit) begin
                deg_nxt = (deg_mul > 12'(ngp_pkg::DEG_ACC_MAX)) ? ngp_pkg::DEG_ACC_MAX :
                          deg_mul[7:0];
              end else begin
                stop_nxt = 1'b1;
              end
            end else begin
              // minutes restart fresh after the degree digits
              stop_nxt = stop_eff;
              if (!stop_eff) begin
                if (is_digit) begin
                  if (!(frac_r && (seen_r >= ngp_pkg::FRAC_LIM))) begin
                    if (frac_r) begin
                      seen_nxt = seen_r + 3'd1;
                    end
                    min_nxt = (min_mul > 27'(ngp_pkg::MIN_ACC_MAX)) ? ngp_pkg::MIN_ACC_MAX :
                              min_mul[22:0];
                  end
                end else if ((in_rx_byte == ngp_pkg::CH_DOT) && !frac_r) begin
                  frac_nxt = 1'b1;
                end else begin
                  stop_nxt = 1'b1;
                end
              end
            end
            if (dig_r < ngp_pkg::DIG_MAX) begin
              dig_nxt = dig_r + 4'd1;
            end
          end
        end
        ngp_pkg::FLD_NS, ngp_pkg::FLD_EW: begin
          if (in_rx_byte == ngp_pkg::CH_COMMA) begin
            fi_nxt    = ngp_pkg::field_t'(fi_r + 3'd1);
            clear_req = 1'b1;
          end else begin
            // only the first hemisphere character counts
            if (dig_r == 4'd0) begin
              if ((fi_r == ngp_pkg::FLD_NS) && (in_rx_byte == ngp_pkg::CH_S)) begin
                latneg_nxt = 1'b1;
              end
              if ((fi_r == ngp_pkg::FLD_EW) && (in_rx_byte == ngp_pkg::CH_W)) begin
                lonneg_nxt = 1'b1;
              end
            end
            if (dig_r < ngp_pkg::DIG_MAX) begin
              dig_nxt = dig_r + 4'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (clear_req) begin
      dig_nxt  = 4'd0;
      stop_nxt = 1'b0;
      frac_nxt = 1'b0;
      deg_nxt  = 8'd0;
      min_nxt  = 23'd0;
      seen_nxt = 3'd0;
    end

    if (line_end) begin
      cp_nxt     = 3'd0;
      hok_nxt    = 1'b1;
      fi_nxt     = ngp_pkg::FLD_TIME;
      dig_nxt    = 4'd0;
      stop_nxt   = 1'b0;
      frac_nxt   = 1'b0;
      deg_nxt    = 8'd0;
      min_nxt    = 23'd0;
      seen_nxt   = 3'd0;
      latneg_nxt = 1'b0;
      lonneg_nxt = 1'b0;
      pr_nxt     = ngp_pkg::ST_INCOMPLETE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cp_r     <= 3'd0;
      hok_r    <= 1'b1;
      fi_r     <= ngp_pkg::FLD_TIME;
      dig_r    <= 4'd0;
      stop_r   <= 1'b0;
      frac_r   <= 1'b0;
      deg_r    <= 8'd0;
      min_r    <= 23'd0;
      seen_r   <= 3'd0;
      latneg_r <= 1'b0;
      lonneg_r <= 1'b0;
      pr_r     <= ngp_pkg::ST_INCOMPLETE;
    end else if (in_acc) begin
      cp_r     <= cp_nxt;
      hok_r    <= hok_nxt;
      fi_r     <= fi_nxt;
      dig_r    <= dig_nxt;
      stop_r   <= stop_nxt;
      frac_r   <= frac_nxt;
      deg_r    <= deg_nxt;
      min_r    <= min_nxt;
      seen_r   <= seen_nxt;
      latneg_r <= latneg_nxt;
      lonneg_r <= lonneg_nxt;
      pr_r     <= pr_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Magnitude pipeline: deg * 1e7 + round(min * 10^(7-seen) / 60), saturated
  // --------------------------------------------------------------------------
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  logic tail_take, emit_take;
  logic out_valid_r;

  ngp_pkg::job_t job_in;
  ngp_pkg::job_t job1_r, job2_r, job3_r, job4_r, job5_r, job6_r;

  logic [46:0] m1_r;
  logic [31:0] degp1_r, degp2_r, degp3_r, degp4_r, degp5_r;
  logic [47:0] x2_sum;
  logic [36:0] x2_r;
  logic        sat2_r, sat3_r, sat4_r, sat5_r;
  logic [43:0] qh_prod;
  logic [13:0] qh3_r, qh4_r;
  logic [18:0] hi3_r;
  logic [17:0] lo3_r;
  logic [18:0] rem3;
  logic [23:0] y4_r;
  logic [48:0] ql_prod;
  logic [31:0] q5_r;
  logic [32:0] tot5;
  logic [30:0] lim5;
  logic [30:0] mag6_r;
  logic [30:0] lat_mag_r, lon_mag_r;

  assign tail_take = v6_r && ((job6_r.kind != ngp_pkg::JOB_EMIT) || !out_valid_r || !out_stall);
  assign emit_take = tail_take && (job6_r.kind == ngp_pkg::JOB_EMIT);
  assign rdy6      = !v6_r || tail_take;
  assign rdy5      = !v5_r || rdy6;
  assign rdy4      = !v4_r || rdy5;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;

  assign in_stall  = !rdy1;
  assign in_acc    = in_valid && !in_stall;

  assign job_in.kind    = issue_kind;
  assign job_in.status  = pr_r;
  assign job_in.lat_neg = latneg_r;
  assign job_in.lon_neg = lonneg_r;

  assign x2_sum  = {1'b0, m1_r} + 48'd30;
  assign qh_prod = 44'(x2_r[36:18]) * 44'(ngp_pkg::DIV60_RECIP);
  assign rem3    = hi3_r - 19'(20'(qh3_r) * 20'd60);
  assign ql_prod = 49'(y4_r) * 49'(ngp_pkg::DIV60_RECIP);
  assign tot5    = 33'(degp5_r) + 33'(q5_r);
  assign lim5    = (job5_r.kind == ngp_pkg::JOB_LAT) ? ngp_pkg::LAT_LIMIT : ngp_pkg::LON_LIMIT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_acc && issue;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      job1_r  <= job_in;
      m1_r    <= 47'(min_r) * 47'(ngp_pkg::frac_scale(seen_r));
      degp1_r <= 32'(deg_r) * 32'(ngp_pkg::DEG_SCALE);
    end
    if (rdy2) begin
      job2_r  <= job1_r;
      sat2_r  <= (x2_sum >= ngp_pkg::MIN_SAT);
      x2_r    <= x2_sum[36:0];
      degp2_r <= degp1_r;
    end
    if (rdy3) begin
      job3_r  <= job2_r;
      sat3_r  <= sat2_r;
      hi3_r   <= x2_r[36:18];
      lo3_r   <= x2_r[17:0];
      qh3_r   <= 14'(qh_prod >> 30);
      degp3_r <= degp2_r;
    end
    if (rdy4) begin
      job4_r  <= job3_r;
      sat4_r  <= sat3_r;
      qh4_r   <= qh3_r;
      y4_r    <= {rem3[5:0], lo3_r};
      degp4_r <= degp3_r;
    end
    if (rdy5) begin
      job5_r  <= job4_r;
      sat5_r  <= sat4_r;
      q5_r    <= {qh4_r, ql_prod[47:30]};
      degp5_r <= degp4_r;
    end
    if (rdy6) begin
      job6_r  <= job5_r;
      mag6_r  <= (sat5_r || (tot5 > 33'(lim5))) ? lim5 : tot5[30:0];
    end
    if (tail_take && (job6_r.kind == ngp_pkg::JOB_LAT)) begin
      lat_mag_r <= mag6_r;
    end
    if (tail_take && (job6_r.kind == ngp_pkg::JOB_LON)) begin
      lon_mag_r <= mag6_r;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic [1:0]         status_r;
  logic signed [30:0] lat_r;
  logic signed [31:0] lon_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      status_r <= job6_r.status;
      if (job6_r.status == ngp_pkg::ST_VALID) begin
        lat_r <= job6_r.lat_neg ? (31'sd0 - $signed(lat_mag_r)) : $signed(lat_mag_r);
        lon_r <= job6_r.lon_neg ? (32'sd0 - $signed({1'b0, lon_mag_r})) :
                 $signed({1'b0, lon_mag_r});
      end else begin
        lat_r <= 31'sd0;
        lon_r <= 32'sd0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_latitude_e7  = lat_r;
  assign out_longitude_e7 = lon_r;

endmodule

// ===== design/ngp_checker.sv =====
// ----------------------------------------------------------------------------
// NMEA GGA position parser checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "nmea_gga_position_parser_assert.svh"

module ngp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic signed [30:0] out_latitude_e7,
  input logic signed [31:0] out_longitude_e7
);

  logic        out_held;
  logic        out_fix;
  logic        out_nofix;
  logic        coord_zero;
  logic        lat_ok;
  logic [64:0] out_word;

  assign out_held   = out_valid && out_stall;
  assign out_fix    = out_valid && (out_status == ngp_pkg::ST_VALID);
  assign out_nofix  = out_valid && (out_status != ngp_pkg::ST_VALID);
  assign coord_zero = (out_latitude_e7 == 31'sd0) && (out_longitude_e7 == 32'sd0);
  assign lat_ok     = (out_latitude_e7 <= 31'sd900000000) &&
                      (out_latitude_e7 >= -31'sd900000000);
  assign out_word   = {out_status, out_latitude_e7, out_longitude_e7};

  // a stalled result stays offered
  `NGP_ASSERT_NEXT(a_out_hold, out_held, out_valid, "result dropped under stall")

  // a stalled result keeps its position
  `NGP_ASSERT_NEXT(a_out_stable, out_held, $stable(out_word), "result changed under stall")

  // no fix or incomplete lines carry zero coordinates
  `NGP_ASSERT_SAME(a_zero_coord, out_nofix, coord_zero, "nonzero coordinate without fix")

  // latitude magnitude saturates at 90 degrees
  `NGP_ASSERT_SAME(a_lat_range, out_fix, lat_ok, "latitude out of range")

  // input backs up only behind a held result
  `NGP_ASSERT_SAME(a_stall_cause, in_stall, out_held, "input stalled without held result")

endmodule

bind nmea_gga_position_parser ngp_checker u_ngp_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GGA position parser testbench
// Feeds directed and random serial lines through the parser and checks every
// position fix against a byte-level parser model kept in a scoreboard.
// ----------------------------------------------------------------------------

typedef struct {
  ngp_pkg::status_t   status;
  logic signed [30:0] lat;
  logic signed [31:0] lon;
} gga_fix_t;

class gga_fix_board;
  gga_fix_t    fixes_due[$];
  int          errors;
  int          fixes_noted;
  int          lines_seen;
  int          by_status[3];
  string       gga_tag = "$GPGGA";

  // Line parser state
  int unsigned      col;
  bit               hdr_ok;
  ngp_pkg::field_t  fld;
  int unsigned      chars;
  bit               stopped;
  bit               frac_on;
  int unsigned      deg_acc;
  longint unsigned  min_acc;
  int unsigned      frac_cnt;
  longint           lat_val;
  longint           lon_val;
  ngp_pkg::status_t verdict;

  function new();
    start_line();
  endfunction

  function void clear_coord();
    chars    = 0;
    stopped  = 0;
    frac_on  = 0;
    deg_acc  = 0;
    min_acc  = 0;
    frac_cnt = 0;
  endfunction

  function void start_line();
    col     = 0;
    hdr_ok  = 1;
    fld     = ngp_pkg::FLD_TIME;
    clear_coord();
    lat_val = 0;
    lon_val = 0;
    verdict = ngp_pkg::ST_INCOMPLETE;
  endfunction

  function int pending();
    return fixes_due.size();
  endfunction

  // Degrees plus rounded minutes/60, in 1e-7 degree, clipped to the limit
  function longint scaled(longint limit);
    longint unsigned m;
    longint unsigned total;
    int unsigned     seen;
    int unsigned     k;
    seen = (frac_cnt > 7) ? 7 : frac_cnt;
    m = min_acc;
    for (k = seen; k < 7; k++) m = m * 10;
    total = longint'(deg_acc) * 10000000 + (m + 30) / 60;
    if (total > limit) total = limit;
    return longint'(total);
  endfunction

  function void coord_char(logic [7:0] b, int unsigned deg_len);
    bit          is_dig;
    int unsigned d;
    is_dig = (b >= ngp_pkg::CH_ZERO) && (b <= ngp_pkg::CH_NINE);
    d = is_dig ? int'(b - ngp_pkg::CH_ZERO) : 0;
    if (chars < deg_len) begin
      if (!stopped && is_dig) begin
        deg_acc = deg_acc * 10 + d;
        if (deg_acc > 255) deg_acc = 255;
      end else begin
        stopped = 1;
      end
      return;
    end
    // minutes start fresh after the degree digits
    if (chars == deg_len) stopped = 0;
    if (stopped) return;
    if (is_dig) begin
      if (frac_on) begin
        if (frac_cnt >= ngp_pkg::FRAC_LIM) return;
        frac_cnt++;
      end
      min_acc = min_acc * 10 + d;
      if (min_acc > ngp_pkg::MIN_ACC_MAX) min_acc = ngp_pkg::MIN_ACC_MAX;
    end else if (b == ngp_pkg::CH_DOT && !frac_on) begin
      frac_on = 1;
    end else begin
      stopped = 1;
    end
  endfunction

  function void take_byte(logic [7:0] b);
    gga_fix_t fix;
    if (b == ngp_pkg::CH_LF) return;
    if (b == ngp_pkg::CH_CR) begin
      lines_seen++;
      if (hdr_ok && col >= ngp_pkg::HDR_LEN) begin
        fix.status = verdict;
        fix.lat    = '0;
        fix.lon    = '0;
        if (verdict == ngp_pkg::ST_VALID) begin
          fix.lat = lat_val[30:0];
          fix.lon = lon_val[31:0];
        end
        fixes_due.push_back(fix);
        fixes_noted++;
      end
      start_line();
      return;
    end
    if (col < ngp_pkg::SKIP_LEN) begin
      if (col < ngp_pkg::HDR_LEN && b != gga_tag[col]) hdr_ok = 0;
      col++;
      return;
    end
    if (!hdr_ok) return;
    case (fld)
      ngp_pkg::FLD_TIME: begin
        if (b == ngp_pkg::CH_COMMA) begin
          fld = ngp_pkg::FLD_LAT;
          clear_coord();
        end
      end
      ngp_pkg::FLD_LAT, ngp_pkg::FLD_LON: begin
        if (b == ngp_pkg::CH_COMMA) begin
          if (fld == ngp_pkg::FLD_LAT && chars == 0) begin
            verdict = ngp_pkg::ST_NOFIX;
            fld     = ngp_pkg::FLD_REST;
          end else if (fld == ngp_pkg::FLD_LAT) begin
            lat_val = scaled(ngp_pkg::LAT_LIMIT);
            fld     = ngp_pkg::FLD_NS;
          end else begin
            lon_val = scaled(ngp_pkg::LON_LIMIT);
            verdict = ngp_pkg::ST_VALID;
            fld     = ngp_pkg::FLD_EW;
          end
          clear_coord();
        end else begin
          coord_char(b, (fld == ngp_pkg::FLD_LAT) ? 2 : 3);
          if (chars < ngp_pkg::DIG_MAX) chars++;
        end
      end
      ngp_pkg::FLD_NS, ngp_pkg::FLD_EW: begin
        if (b == ngp_pkg::CH_COMMA) begin
          fld = (fld == ngp_pkg::FLD_NS) ? ngp_pkg::FLD_LON : ngp_pkg::FLD_REST;
          clear_coord();
        end else begin
          // only the first character of the hemisphere decides
          if (chars == 0) begin
            if (fld == ngp_pkg::FLD_NS && b == ngp_pkg::CH_S) lat_val = -lat_val;
            if (fld == ngp_pkg::FLD_EW && b == ngp_pkg::CH_W) lon_val = -lon_val;
          end
          if (chars < ngp_pkg::DIG_MAX) chars++;
        end
      end
      default: ;
    endcase
  endfunction

  function void check_fix(logic [1:0] status, logic signed [30:0] lat,
                          logic signed [31:0] lon);
    gga_fix_t want;
    if (fixes_due.size() == 0) begin
      errors++;
      $display("%0t: unexpected fix: expected none, got status %0d lat %0d lon %0d",
               $time, status, lat, lon);
      return;
    end
    want = fixes_due.pop_front();
    if (status <= 2) by_status[status]++;
    if (status !== want.status) begin
      errors++;
      $display("%0t: status expected %0d actual %0d", $time, want.status, status);
    end
    if (lat !== want.lat) begin
      errors++;
      $display("%0t: latitude expected %0d actual %0d", $time, want.lat, lat);
    end
    if (lon !== want.lon) begin
      errors++;
      $display("%0t: longitude expected %0d actual %0d", $time, want.lon, lon);
    end
  endfunction
endclass

module tb;
  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         in_rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         out_status;
  logic signed [30:0] out_latitude_e7;
  logic signed [31:0] out_longitude_e7;

  gga_fix_board board = new();
  int           bytes_sent = 0;
  logic [7:0]   line_q[$];

  nmea_gga_position_parser DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_latitude_e7  (out_latitude_e7),
    .out_longitude_e7 (out_longitude_e7)
  );

  always #10 clk = ~clk;

  // Both sides run without gaps over this span of the byte stream
  function automatic bit quiet_span();
    return bytes_sent >= 300 && bytes_sent < 700;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.take_byte(b);
    bytes_sent++;
    if (!quiet_span() && $urandom_range(99) < 25) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
  endtask

  task automatic send_line(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(ngp_pkg::CH_CR);
  endtask

  function automatic logic [7:0] any_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == ngp_pkg::CH_CR);
    return b;
  endfunction

  function automatic void push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endfunction

  function automatic void push_digits(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) line_q.push_back(8'(ngp_pkg::CH_ZERO + $urandom_range(9)));
  endfunction

  function automatic void push_coord(input int unsigned deg_len);
    string odd = "-.+x ,";
    push_digits(($urandom_range(9) < 8) ? deg_len : $urandom_range(0, deg_len + 2));
    if ($urandom_range(9) < 8) begin
      line_q.push_back(8'(ngp_pkg::CH_ZERO + $urandom_range(5)));
      push_digits(1);
    end else begin
      push_digits($urandom_range(0, 3));
    end
    if ($urandom_range(99) < 85) begin
      line_q.push_back(ngp_pkg::CH_DOT);
      push_digits($urandom_range(0, 8));
    end
    if ($urandom_range(9) == 0) begin
      line_q.push_back(odd[$urandom_range(0, 4)]);
      push_digits($urandom_range(0, 3));
    end
  endfunction

  function automatic void push_hemi(input logic [7:0] pos, input logic [7:0] neg);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40)      line_q.push_back(pos);
    else if (pick < 80) line_q.push_back(neg);
    else if (pick < 90) ;
    else                line_q.push_back(any_byte());
    if ($urandom_range(9) == 0) line_q.push_back(any_byte());
  endfunction

  function automatic void build_gga();
    push_text("$GPGGA,");
    push_digits($urandom_range(0, 6));
    if ($urandom_range(1)) begin
      line_q.push_back(ngp_pkg::CH_DOT);
      push_digits($urandom_range(0, 3));
    end
    line_q.push_back(ngp_pkg::CH_COMMA);
    if ($urandom_range(9) != 0) push_coord(2);
    line_q.push_back(ngp_pkg::CH_COMMA);
    push_hemi(8'h4E, ngp_pkg::CH_S);
    line_q.push_back(ngp_pkg::CH_COMMA);
    push_coord(3);
    line_q.push_back(ngp_pkg::CH_COMMA);
    push_hemi(8'h45, ngp_pkg::CH_W);
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(any_byte());
    end else begin
      push_text(",1,08,0.9,545.4,M,46.9,M,,*47");
    end
  endfunction

  // Build one random line in line_q, without its CR
  function automatic void build_random_line();
    int unsigned kind;
    int unsigned cut;
    string       tag = "$GPGGA";
    line_q.delete();
    kind = $urandom_range(99);
    if (kind < 72) begin
      build_gga();
      if ($urandom_range(99) < 15) begin
        cut = $urandom_range(0, line_q.size() - 1);
        while (line_q.size() > cut) void'(line_q.pop_back());
      end else if ($urandom_range(99) < 10) begin
        line_q[$urandom_range(7, line_q.size() - 1)] = any_byte();
      end
    end else if (kind < 82) begin
      build_gga();
      line_q[$urandom_range(0, 5)] = any_byte();
    end else if (kind < 93) begin
      repeat ($urandom_range(0, 30)) line_q.push_back(any_byte());
    end else begin
      cut = $urandom_range(0, 6);
      for (int i = 0; i < cut; i++) line_q.push_back(tag[i]);
    end
  endfunction

  // Result side: check each transfer, stall at random, one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        board.check_fix(out_status, out_latitude_e7, out_longitude_e7);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!hold_done && bytes_sent >= 900) begin
        hold_done = 1;
        hold_left = 400;
        out_stall <= 1'b1;
      end else if (quiet_span()) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  initial begin
    bit paused;
    paused = 0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_rx_byte <= 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_line("$GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,");
    send_line("$GPGGA,,9000.0000,S,18000.0000,W,1");
    send_line("$GPGGA,,99999999999,N,99999999999999,E");
    send_line("$GPGGA,,0000.12345678,X,00000.99999999,Wx");
    send_line("$GPGGA,,-123.4,S,1.5.6,W");
    send_line("$GPGGA,,1,,,W");
    send_line("$GPGGA,,,N,01131.000,E");
    send_line("$GPGGA,1,4807.038,N,011");
    send_line("$GPGGA");
    send_line("$GPGG");
    send_line("$GPGSA,,4807.038,N,01131.000,E");
    send_line("");
    // line feed, NUL and 0xFF at the start of a line, ahead of its header
    send_byte(ngp_pkg::CH_LF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_line("$GPGGA,12,4807.0,S,01131.0,W");

    while (bytes_sent < 1750) begin
      if (!paused && bytes_sent >= 1300) begin
        // hold the input until the parser has drained
        paused = 1;
        in_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
      end
      build_random_line();
      foreach (line_q[i]) send_byte(line_q[i]);
      send_byte(ngp_pkg::CH_CR);
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (20) @(posedge clk);

    if (board.pending() != 0) begin
      board.errors++;
      $display("%0t: %0d fixes expected but never delivered", $time, board.pending());
    end
    $display("run covered %0d bytes in %0d lines and compared %0d fixes",
             bytes_sent, board.lines_seen, board.fixes_noted);
    $display("fix outcomes: %0d valid, %0d no fix, %0d incomplete",
             board.by_status[0], board.by_status[1], board.by_status[2]);
    if (board.errors == 0)
      $display("nmea_gga_position_parser: match");
    else
      $display("nmea_gga_position_parser: mismatch");
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: run timed out", $time);
    $display("nmea_gga_position_parser: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+design
design/ngp_pkg.sv
design/nmea_gga_position_parser.sv
design/ngp_checker.sv
dv/tb.sv
